FILE: src/xoshiro256ss_ranged_generator_unit_defines.svh
// Assertion macros used by the checker file of the ranged generator.
// No dependencies.
`ifndef XOSHIRO256SS_RANGED_GENERATOR_UNIT_DEFINES_SVH
`define XOSHIRO256SS_RANGED_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst_n is low.
`define XRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define XRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/xrg_pkg.sv
// Types and constants shared by the ranged generator modules.
// No dependencies.
package xrg_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned OUT_W    = 32;
    localparam int unsigned VALUE_W  = 33;
    localparam int unsigned LIMIT_W  = 31;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned NUM_SEED = 4;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned ADDR_W   = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_RAW    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RANGE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNIT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SIGNED = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESEED = 3'd4;

    // Generator constants.
    localparam int unsigned ROT_SCRAMBLE = 7;
    localparam int unsigned ROT_S3       = 45;
    localparam int unsigned SHIFT_T      = 17;
    localparam int unsigned SHIFT_MUL5   = 2;
    localparam int unsigned SHIFT_MUL9   = 3;
    localparam int unsigned FRAC_SHIFT   = 8;
    localparam logic [VALUE_W-1:0] SIGNED_OFFSET = 33'h1_0000_0000 >> FRAC_SHIFT;

    // Status codes.
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NOT_SEEDED = 1'b1;

    // Seed register reset values.
    localparam logic [WORD_W-1:0] SEED0_RESET = 64'd1;
    localparam logic [WORD_W-1:0] SEEDN_RESET = 64'd0;

    typedef logic [NUM_SEED-1:0][WORD_W-1:0] seed_arr_t;

    typedef enum logic [1:0] {
        KIND_ZERO_OK,
        KIND_NOT_SEEDED,
        KIND_DRAWN
    } out_kind_t;

    typedef enum logic {
        DIV_SRC_THRESH,
        DIV_SRC_WORD
    } div_src_t;

    typedef struct packed {
        logic      latch_in;
        logic      load_seeds;
        logic      draw;
        logic      scramble;
        logic      div_start;
        div_src_t  div_src;
        logic      thr_load;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             limit_small;
        logic             seeded;
        logic             seeds_zero;
        logic             div_busy;
        logic             below_thr;
    } sts_t;

endpackage

FILE: src/xrg_dpath.sv
// Datapath of the ranged generator: state, scrambler, remainder unit, result.
// Depends on xrg_pkg.
module xrg_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  xrg_pkg::cmd_t                       cmd,
    output xrg_pkg::sts_t                       sts,
    input  logic [xrg_pkg::REQ_W-1:0]           s_req_type,
    input  logic [xrg_pkg::LIMIT_W-1:0]         s_limit,
    input  xrg_pkg::seed_arr_t                  seeds,
    output logic signed [xrg_pkg::VALUE_W-1:0]  m_value,
    output logic                                m_status
);

    logic [xrg_pkg::WORD_W-1:0]  state_reg [xrg_pkg::NUM_SEED];
    logic                        seeded_reg;
    logic [xrg_pkg::REQ_W-1:0]   req_reg;
    logic [xrg_pkg::LIMIT_W-1:0] limit_reg;
    logic [xrg_pkg::WORD_W-1:0]  p_reg;
    logic [xrg_pkg::OUT_W-1:0]   w_reg;
    logic [xrg_pkg::OUT_W-1:0]   thr_reg;
    logic [xrg_pkg::OUT_W-1:0]   dvd_reg;
    logic [xrg_pkg::OUT_W-1:0]   rem_reg;
    logic [xrg_pkg::CNT_W-1:0]   cnt_reg;
    logic                        busy_reg;
    logic [xrg_pkg::VALUE_W-1:0] value_reg;
    logic                        status_reg;

    logic [xrg_pkg::WORD_W-1:0]  s0, s1, s2, s3, t, x3, mul5, p_next;
    logic [xrg_pkg::WORD_W-1:0]  mul9;
    logic [xrg_pkg::OUT_W-1:0]   rem_shift, rem_next, neg_limit;
    logic [xrg_pkg::VALUE_W-1:0] value_next;
    logic [xrg_pkg::OUT_W-1:0]   divisor;

    assign s0 = state_reg[0];
    assign s1 = state_reg[1];
    assign s2 = state_reg[2];
    assign s3 = state_reg[3];
    assign t  = s1 << xrg_pkg::SHIFT_T;
    assign x3 = s3 ^ s1;

    // s1 * 5, rotated left by 7; the * 9 follows in the next cycle.
    assign mul5   = (s1 << xrg_pkg::SHIFT_MUL5) + s1;
    assign p_next = (mul5 << xrg_pkg::ROT_SCRAMBLE)
                  | (mul5 >> (xrg_pkg::WORD_W - xrg_pkg::ROT_SCRAMBLE));
    assign mul9   = (p_reg << xrg_pkg::SHIFT_MUL9) + p_reg;

    // Restoring remainder, one dividend bit per cycle. The remainder stays
    // below the limit, so its top bit is always clear before the shift.
    assign divisor   = {1'b0, limit_reg};
    assign rem_shift = {rem_reg[xrg_pkg::OUT_W-2:0], dvd_reg[xrg_pkg::OUT_W-1]};
    assign rem_next  = (rem_shift >= divisor) ? (rem_shift - divisor) : rem_shift;
    assign neg_limit = '0 - divisor;

    always_comb begin
        value_next = '0;
        unique case (cmd.out_kind)
            xrg_pkg::KIND_ZERO_OK, xrg_pkg::KIND_NOT_SEEDED: value_next = '0;
            xrg_pkg::KIND_DRAWN: begin
                unique case (req_reg)
                    xrg_pkg::REQ_RANGE: value_next = {1'b0, rem_reg};
                    xrg_pkg::REQ_UNIT:
                        value_next = {{(xrg_pkg::FRAC_SHIFT + 1){1'b0}},
                                      w_reg[xrg_pkg::OUT_W-1:xrg_pkg::FRAC_SHIFT]};
                    xrg_pkg::REQ_SIGNED:
                        value_next = {{xrg_pkg::FRAC_SHIFT{1'b0}},
                                      w_reg[xrg_pkg::OUT_W-1:xrg_pkg::FRAC_SHIFT], 1'b0}
                                   - xrg_pkg::SIGNED_OFFSET;
                    default: value_next = {1'b0, w_reg};
                endcase
            end
            default: value_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < xrg_pkg::NUM_SEED; i++) begin
                state_reg[i] <= '0;
            end
            seeded_reg <= 1'b0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cmd.load_seeds) begin
                for (int i = 0; i < xrg_pkg::NUM_SEED; i++) begin
                    state_reg[i] <= seeds[i];
                end
                seeded_reg <= 1'b1;
            end else if (cmd.draw) begin
                state_reg[0] <= s0 ^ x3;
                state_reg[1] <= s1 ^ s2 ^ s0;
                state_reg[2] <= s2 ^ s0 ^ t;
                state_reg[3] <= (x3 << xrg_pkg::ROT_S3)
                              | (x3 >> (xrg_pkg::WORD_W - xrg_pkg::ROT_S3));
            end
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            req_reg   <= s_req_type;
            limit_reg <= s_limit;
        end
        if (cmd.draw) begin
            p_reg <= p_next;
        end
        if (cmd.scramble) begin
            w_reg <= mul9[xrg_pkg::WORD_W-1:xrg_pkg::WORD_W-xrg_pkg::OUT_W];
        end
        if (cmd.div_start) begin
            dvd_reg <= (cmd.div_src == xrg_pkg::DIV_SRC_WORD) ? w_reg : neg_limit;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
        if (cmd.thr_load) begin
            thr_reg <= rem_reg;
        end
        if (cmd.out_load) begin
            value_reg  <= value_next;
            status_reg <= (cmd.out_kind == xrg_pkg::KIND_NOT_SEEDED)
                        ? xrg_pkg::STATUS_NOT_SEEDED : xrg_pkg::STATUS_OK;
        end
    end

    assign sts.req_type    = req_reg;
    assign sts.limit_small = (limit_reg[xrg_pkg::LIMIT_W-1:1] == '0);
    assign sts.seeded      = seeded_reg;
    assign sts.seeds_zero  = (seeds == '0);
    assign sts.div_busy    = busy_reg;
    assign sts.below_thr   = (w_reg < thr_reg);

    assign m_value  = value_reg;
    assign m_status = status_reg;

endmodule

FILE: src/xrg_ctrl.sv
// Controller of the ranged generator: request sequencing and result handshake.
// Depends on xrg_pkg.
module xrg_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output xrg_pkg::cmd_t cmd,
    input  xrg_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_THRESH,
        ST_DRAW,
        ST_SCRAMBLE,
        ST_CHECK,
        ST_MOD,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    xrg_pkg::out_kind_t  kind_reg, kind_next;
    logic                m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.out_kind = kind_reg;
        cmd.latch_in = s_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (sts.req_type == xrg_pkg::REQ_RESEED) begin
                    if (sts.seeds_zero) begin
                        kind_next = xrg_pkg::KIND_NOT_SEEDED;
                    end else begin
                        kind_next      = xrg_pkg::KIND_ZERO_OK;
                        cmd.load_seeds = 1'b1;
                    end
                    state_next = ST_DONE;
                end else if (sts.req_type > xrg_pkg::REQ_RESEED) begin
                    kind_next  = xrg_pkg::KIND_ZERO_OK;
                    state_next = ST_DONE;
                end else if (sts.req_type == xrg_pkg::REQ_RANGE && sts.limit_small) begin
                    kind_next  = xrg_pkg::KIND_ZERO_OK;
                    state_next = ST_DONE;
                end else if (!sts.seeded && sts.seeds_zero) begin
                    kind_next  = xrg_pkg::KIND_NOT_SEEDED;
                    state_next = ST_DONE;
                end else begin
                    cmd.load_seeds = !sts.seeded;
                    if (sts.req_type == xrg_pkg::REQ_RANGE) begin
                        cmd.div_start = 1'b1;
                        cmd.div_src   = xrg_pkg::DIV_SRC_THRESH;
                        state_next    = ST_THRESH;
                    end else begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_THRESH: begin
                if (!sts.div_busy) begin
                    cmd.thr_load = 1'b1;
                    state_next   = ST_DRAW;
                end
            end
            ST_DRAW: begin
                cmd.draw   = 1'b1;
                state_next = ST_SCRAMBLE;
            end
            ST_SCRAMBLE: begin
                cmd.scramble = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (sts.req_type != xrg_pkg::REQ_RANGE) begin
                    kind_next  = xrg_pkg::KIND_DRAWN;
                    state_next = ST_DONE;
                end else if (sts.below_thr) begin
                    state_next = ST_DRAW;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = xrg_pkg::DIV_SRC_WORD;
                    state_next    = ST_MOD;
                end
            end
            ST_MOD: begin
                if (!sts.div_busy) begin
                    kind_next  = xrg_pkg::KIND_DRAWN;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= xrg_pkg::KIND_ZERO_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: src/xoshiro256ss_ranged_generator_unit.sv
// Top level of the xoshiro256** ranged generator: seed registers and APB port.
// Depends on xrg_pkg, xrg_ctrl and xrg_dpath.
//
// Usage. A request word on the s_ channel (s_req_type, s_limit) asks for one
// draw: raw 32-bit word, a value in 0..limit-1, a 24-bit unit fraction, a
// signed fraction, or a reseed from the four 64-bit seed registers. Every
// request gives exactly one result word on the m_ channel (m_value, m_status).
// The seed registers sit at byte addresses 0, 8, 16 and 24 of the APB port and
// are copied into the generator on a reseed request and when it seeds itself.
//
// Sequencing. The block works on one request at a time and takes a new one only
// in its idle state, which it reenters when a result is written. Raw, unit and
// signed draws go from dispatch through the draw, scramble and check states to
// the result. Range draws run the remainder unit twice (threshold, then the final
// modulo), plus a draw, scramble and check per rejected word. Reseed, unused
// codes, limits of 0 or 1 and not-seeded results go from dispatch to the result.
//
// Reset clears the generator state, the seeded flag and both channels; seed
// word 0 resets to 1, the others to 0. The result sits in an output register:
// while the receiver stalls, the next request is accepted and processed, and
// only its final write to the output register waits for the slot to free up.
module xoshiro256ss_ranged_generator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [xrg_pkg::REQ_W-1:0]           s_req_type,
    input  logic [xrg_pkg::LIMIT_W-1:0]         s_limit,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [xrg_pkg::VALUE_W-1:0]  m_value,
    output logic                                m_status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xrg_pkg::ADDR_W-1:0]          paddr,
    input  logic [xrg_pkg::WORD_W-1:0]          pwdata,
    output logic [xrg_pkg::WORD_W-1:0]          prdata,
    output logic                                pready
);

    xrg_pkg::seed_arr_t seed_reg;
    xrg_pkg::cmd_t      cmd;
    xrg_pkg::sts_t      sts;
    logic [1:0]         reg_idx;

    // Registers are 8 bytes apart, so the index is the address above bit 2.
    assign reg_idx = paddr[xrg_pkg::ADDR_W-1:3];
    assign pready  = 1'b1;
    assign prdata  = seed_reg[reg_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg[0] <= xrg_pkg::SEED0_RESET;
            seed_reg[1] <= xrg_pkg::SEEDN_RESET;
            seed_reg[2] <= xrg_pkg::SEEDN_RESET;
            seed_reg[3] <= xrg_pkg::SEEDN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            seed_reg[reg_idx] <= pwdata;
        end
    end

    // The controller sequences each request; the datapath holds the state.
    xrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    xrg_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_req_type (s_req_type),
        .s_limit    (s_limit),
        .seeds      (seed_reg),
        .m_value    (m_value),
        .m_status   (m_status)
    );

endmodule

FILE: src/xrg_checker.sv
// Port-level checks of the ranged generator, bound to its top level.
// Depends on xoshiro256ss_ranged_generator_unit_defines.svh.
`include "xoshiro256ss_ranged_generator_unit_defines.svh"

module xrg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [32:0] m_value,
    input logic        m_status
);

    // A reset leaves no result word pending.
    `XRG_ASSERT_NEXT(a_reset_clears_out, aclk, 1'b1, !aresetn, !m_valid, "m_valid after reset")

    // Requests are handled one at a time.
    `XRG_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "s_ready after accept")

    // A not-seeded report always carries a zero value.
    `XRG_ASSERT_IMP(a_not_seeded_zero, aclk, aresetn, m_valid && m_status, m_value == 33'd0, "status with value")

    // A stalled result word holds.
    `XRG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_status), "result changed under stall")

endmodule

bind xoshiro256ss_ranged_generator_unit xrg_checker u_xrg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_value  (m_value),
    .m_status (m_status)
);
